/* rtl/sphc_pkg.sv */
package sphc_pkg;

    localparam int unsigned POS_W   = 24;
    localparam int unsigned RAD_W   = 23;
    localparam int unsigned SLOT_W  = 6;
    localparam int unsigned NORM_W  = 16;
    localparam int unsigned DEPTH_W = 24;
    localparam int unsigned REL_W   = 25;
    localparam int unsigned MAG_W   = 24;
    localparam int unsigned SQ_W    = 48;
    localparam int unsigned D2_W    = 50;
    localparam int unsigned ROOT_W  = 25;
    localparam int unsigned NUM_W   = 39;
    localparam int unsigned QUO_W   = 15;
    localparam int unsigned FRAC_N  = 14;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_SCAN  = 1'b1;

    typedef struct packed {
        logic                    req_type;
        logic [SLOT_W-1:0]       slot;
        logic                    active;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic [RAD_W-1:0]        radius;
    } sphc_req_t;

    typedef struct packed {
        logic                     hit;
        logic [SLOT_W-1:0]        slot_a;
        logic [SLOT_W-1:0]        slot_b;
        logic signed [NORM_W-1:0] normal_x;
        logic signed [NORM_W-1:0] normal_y;
        logic signed [NORM_W-1:0] normal_z;
        logic [DEPTH_W-1:0]       depth;
        logic                     last;
    } sphc_res_t;

    typedef struct packed {
        logic                    active;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
        logic [RAD_W-1:0]        r;
    } sphc_cell_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SQ,
        ST_CMP,
        ST_SQRT,
        ST_NORM,
        ST_DIV,
        ST_EMIT,
        ST_DONE
    } sphc_state_t;

endpackage

/* rtl/sphc_cell.sv */
module sphc_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                shift,
    input  sphc_pkg::sphc_cell_t from_next,
    input  logic                wr_en,
    input  sphc_pkg::sphc_cell_t wr_data,
    output sphc_pkg::sphc_cell_t q
);

    logic                 active_reg;
    sphc_pkg::sphc_cell_t data_reg;

    // Active mark clears on reset; stored geometry is don't-care until written.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else if (shift)
        begin
            active_reg <= from_next.active;
        end
        else if (wr_en)
        begin
            active_reg <= wr_data.active;
        end
    end

    // Destroy keeps geometry; only a ring shift or a create or keep write overwrites it.
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            data_reg <= from_next;
        end
        else if (wr_en && wr_data.active)
        begin
            data_reg <= wr_data;
        end
    end

    always_comb
    begin
        q        = data_reg;
        q.active = active_reg;
    end

endmodule

/* rtl/sphc_sqrt.sv */
module sphc_sqrt (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [sphc_pkg::D2_W-1:0]        op,
    output logic                             done,
    output logic [sphc_pkg::ROOT_W-1:0]      root
);

    logic [sphc_pkg::D2_W-1:0]   op_reg;
    logic [sphc_pkg::ROOT_W+1:0] rem_reg;
    logic [sphc_pkg::ROOT_W-1:0] root_reg;
    logic [4:0]                  cnt_reg;
    logic                        run_reg;
    logic                        done_reg;

    logic [sphc_pkg::ROOT_W+3:0] rem_sh;
    logic [sphc_pkg::ROOT_W+3:0] trial;
    logic                        ge;

    // One root bit per cycle: bring down two operand bits, try (root << 2) | 1.
    always_comb
    begin
        rem_sh = {rem_reg, op_reg[sphc_pkg::D2_W-1 -: 2]};
        trial  = {2'b00, root_reg, 2'b01};
        ge     = (rem_sh >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= 5'(sphc_pkg::ROOT_W);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            op_reg   <= op;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (run_reg)
        begin
            op_reg   <= {op_reg[sphc_pkg::D2_W-3:0], 2'b00};
            rem_reg  <= ge ? (sphc_pkg::ROOT_W+2)'(rem_sh - trial)
                           : (sphc_pkg::ROOT_W+2)'(rem_sh);
            root_reg <= {root_reg[sphc_pkg::ROOT_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

/* rtl/sphc_div.sv */
module sphc_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [sphc_pkg::NUM_W-1:0]    num,
    input  logic [sphc_pkg::ROOT_W-1:0]   den,
    output logic                          done,
    output logic [sphc_pkg::QUO_W-1:0]    quo
);

    logic [sphc_pkg::QUO_W-1:0]  low_reg;
    logic [sphc_pkg::ROOT_W-1:0] rem_reg;
    logic [sphc_pkg::ROOT_W-1:0] den_reg;
    logic [sphc_pkg::QUO_W-1:0]  quo_reg;
    logic [3:0]                  cnt_reg;
    logic                        run_reg;
    logic                        done_reg;

    logic [sphc_pkg::ROOT_W:0]   rem_sh;
    logic                        ge;

    // Quotient fits in QUO_W bits, so the upper numerator bits start below den.
    always_comb
    begin
        rem_sh = {rem_reg, low_reg[sphc_pkg::QUO_W-1]};
        ge     = (rem_sh >= {1'b0, den_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= 4'(sphc_pkg::QUO_W);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 4'd1;
                if (cnt_reg == 4'd1)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= sphc_pkg::ROOT_W'(num[sphc_pkg::NUM_W-1:sphc_pkg::QUO_W]);
            low_reg <= num[sphc_pkg::QUO_W-1:0];
            den_reg <= den;
            quo_reg <= '0;
        end
        else if (run_reg)
        begin
            rem_reg <= ge ? sphc_pkg::ROOT_W'(rem_sh - {1'b0, den_reg})
                          : sphc_pkg::ROOT_W'(rem_sh);
            low_reg <= {low_reg[sphc_pkg::QUO_W-2:0], 1'b0};
            quo_reg <= {quo_reg[sphc_pkg::QUO_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

/* rtl/sphere_pair_collision_scan_core.sv */
// Sphere pair collision scanner. The collider table lives in a ring of
// NUM_SLOTS cells; a write beat (req_type 0) lands in the addressed cell,
// gives no result, and busy stays low. A scan beat rotates the ring once past
// a single test unit: each slot is loaded, each active slot above an active
// scanned one also takes the squared-distance compare, and each overlap then
// runs the bit-serial square root, three normal divisions through one shared
// divider, and the EMIT state to hold the record; coinciding centers skip the
// divisions. Records appear on res with res_valid high for exactly one cycle
// and must be taken then; there is no backpressure. Every record of an
// overlap is held one step so that the final one can carry last; a scan that
// finds nothing gives a single record with hit low and last high. start is
// taken only while busy is low.
module sphere_pair_collision_scan_core #(
    parameter int unsigned NUM_SLOTS = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  sphc_pkg::sphc_req_t req,
    output logic                res_valid,
    output sphc_pkg::sphc_res_t res
);

    localparam int unsigned KW = $clog2(NUM_SLOTS + 1);

    sphc_pkg::sphc_state_t state_reg, state_next;

    logic [KW-1:0]                    k_reg;
    logic [sphc_pkg::SLOT_W-1:0]      a_slot_reg;
    logic                             a_ok_reg;
    sphc_pkg::sphc_cell_t             a_cell_reg;
    logic [sphc_pkg::SLOT_W-1:0]      b_slot_reg;
    logic signed [sphc_pkg::REL_W-1:0] rel_x_reg, rel_y_reg, rel_z_reg;
    logic [sphc_pkg::DEPTH_W-1:0]     tr_reg;
    logic [sphc_pkg::SQ_W-1:0]        sq_x_reg, sq_y_reg, sq_z_reg, tr2_reg;
    logic [sphc_pkg::ROOT_W-1:0]      dist_reg;
    logic [1:0]                       axis_reg;
    logic [sphc_pkg::NORM_W-1:0]      nx_reg, ny_reg, nz_reg;
    logic                             pend_valid_reg;
    sphc_pkg::sphc_res_t              pend_reg;
    logic                             res_valid_reg;
    sphc_pkg::sphc_res_t              res_reg;

    sphc_pkg::sphc_cell_t cell_q [NUM_SLOTS];
    sphc_pkg::sphc_cell_t head;
    sphc_pkg::sphc_cell_t wr_cell;

    logic                             accept;
    logic                             advance;
    logic                             sqrt_start, sqrt_done;
    logic [sphc_pkg::ROOT_W-1:0]      sqrt_root;
    logic                             div_start, div_done;
    logic [sphc_pkg::QUO_W-1:0]       div_quo;
    logic [sphc_pkg::NUM_W-1:0]       div_num;
    logic                             emit;
    sphc_pkg::sphc_res_t              emit_rec;
    sphc_pkg::sphc_res_t              new_rec;

    logic [sphc_pkg::MAG_W-1:0]       mag_x, mag_y, mag_z, mag_sel;
    logic                             neg_sel;
    logic [sphc_pkg::NORM_W-1:0]      norm_val;
    logic [sphc_pkg::D2_W-1:0]        d2;
    logic                             is_a, at_end;

    assign accept  = start && (state_reg == sphc_pkg::ST_IDLE);
    assign busy    = (state_reg != sphc_pkg::ST_IDLE);
    assign head    = cell_q[0];

    always_comb
    begin
        wr_cell.active = req.active;
        wr_cell.x      = req.pos_x;
        wr_cell.y      = req.pos_y;
        wr_cell.z      = req.pos_z;
        wr_cell.r      = req.radius;
    end

    // Ring of cells: each shift hands every cell the content of the next one,
    // so after k shifts slot k sits at the head. A full turn realigns the ring.
    for (genvar i = 0; i < NUM_SLOTS; i++)
    begin : g_cell
        sphc_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .shift     (advance),
            .from_next (cell_q[(i + 1) % NUM_SLOTS]),
            .wr_en     (accept && (req.req_type == sphc_pkg::REQ_WRITE)
                        && (req.slot == sphc_pkg::SLOT_W'(i))),
            .wr_data   (wr_cell),
            .q         (cell_q[i])
        );
    end

    always_comb
    begin
        mag_x = sphc_pkg::MAG_W'(rel_x_reg[sphc_pkg::REL_W-1] ? -rel_x_reg : rel_x_reg);
        mag_y = sphc_pkg::MAG_W'(rel_y_reg[sphc_pkg::REL_W-1] ? -rel_y_reg : rel_y_reg);
        mag_z = sphc_pkg::MAG_W'(rel_z_reg[sphc_pkg::REL_W-1] ? -rel_z_reg : rel_z_reg);
        case (axis_reg)
            2'd0:
            begin
                mag_sel = mag_x;
                neg_sel = rel_x_reg[sphc_pkg::REL_W-1];
            end
            2'd1:
            begin
                mag_sel = mag_y;
                neg_sel = rel_y_reg[sphc_pkg::REL_W-1];
            end
            default:
            begin
                mag_sel = mag_z;
                neg_sel = rel_z_reg[sphc_pkg::REL_W-1];
            end
        endcase
        // Round to nearest: add half the divisor before the division.
        div_num  = {1'b0, mag_sel, sphc_pkg::FRAC_N'(0)}
                   + sphc_pkg::NUM_W'(dist_reg >> 1);
        norm_val = neg_sel ? sphc_pkg::NORM_W'(-{1'b0, div_quo})
                           : sphc_pkg::NORM_W'({1'b0, div_quo});
        d2       = sphc_pkg::D2_W'(sq_x_reg) + sphc_pkg::D2_W'(sq_y_reg)
                   + sphc_pkg::D2_W'(sq_z_reg);
        is_a     = (7'(k_reg) == 7'(a_slot_reg));
        at_end   = (k_reg == KW'(NUM_SLOTS));
    end

    sphc_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .op    (d2),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

    sphc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (dist_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_comb
    begin
        new_rec.hit      = 1'b1;
        new_rec.slot_a   = a_slot_reg;
        new_rec.slot_b   = b_slot_reg;
        new_rec.normal_x = nx_reg;
        new_rec.normal_y = ny_reg;
        new_rec.normal_z = nz_reg;
        new_rec.depth    = tr_reg - sphc_pkg::DEPTH_W'(dist_reg);
        new_rec.last     = 1'b0;
    end

    // Next state and strobes.
    always_comb
    begin
        state_next = state_reg;
        advance    = 1'b0;
        sqrt_start = 1'b0;
        div_start  = 1'b0;
        emit       = 1'b0;
        emit_rec   = pend_reg;
        case (state_reg)
            sphc_pkg::ST_IDLE:
            begin
                if (accept && (req.req_type == sphc_pkg::REQ_SCAN))
                begin
                    state_next = sphc_pkg::ST_LOAD;
                end
            end
            sphc_pkg::ST_LOAD:
            begin
                if (at_end)
                begin
                    state_next = sphc_pkg::ST_DONE;
                end
                else if (!is_a && a_ok_reg && head.active)
                begin
                    state_next = sphc_pkg::ST_SQ;
                end
                else
                begin
                    advance = 1'b1;
                end
            end
            sphc_pkg::ST_SQ:
            begin
                state_next = sphc_pkg::ST_CMP;
            end
            sphc_pkg::ST_CMP:
            begin
                if (d2 < sphc_pkg::D2_W'(tr2_reg))
                begin
                    sqrt_start = 1'b1;
                    state_next = sphc_pkg::ST_SQRT;
                end
                else
                begin
                    advance    = 1'b1;
                    state_next = sphc_pkg::ST_LOAD;
                end
            end
            sphc_pkg::ST_SQRT:
            begin
                if (sqrt_done)
                begin
                    state_next = sphc_pkg::ST_NORM;
                end
            end
            sphc_pkg::ST_NORM:
            begin
                if (dist_reg == '0)
                begin
                    state_next = sphc_pkg::ST_EMIT;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = sphc_pkg::ST_DIV;
                end
            end
            sphc_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = (axis_reg == 2'd2) ? sphc_pkg::ST_EMIT
                                                    : sphc_pkg::ST_NORM;
                end
            end
            sphc_pkg::ST_EMIT:
            begin
                // Release the held record; the new one waits for a successor.
                emit       = pend_valid_reg;
                advance    = 1'b1;
                state_next = sphc_pkg::ST_LOAD;
            end
            sphc_pkg::ST_DONE:
            begin
                emit = 1'b1;
                if (pend_valid_reg)
                begin
                    emit_rec.last = 1'b1;
                end
                else
                begin
                    emit_rec          = '0;
                    emit_rec.slot_a   = a_slot_reg;
                    emit_rec.last     = 1'b1;
                end
                state_next = sphc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = sphc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= sphc_pkg::ST_IDLE;
            k_reg          <= '0;
            a_ok_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            axis_reg       <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= emit;
            if (accept)
            begin
                k_reg          <= '0;
                a_ok_reg       <= 1'b0;
                pend_valid_reg <= 1'b0;
            end
            else
            begin
                if (advance)
                begin
                    k_reg <= k_reg + KW'(1);
                end
                if (state_reg == sphc_pkg::ST_LOAD && !at_end && is_a)
                begin
                    a_ok_reg <= head.active;
                end
                if (state_reg == sphc_pkg::ST_EMIT)
                begin
                    pend_valid_reg <= 1'b1;
                end
            end
            if (sqrt_start)
            begin
                axis_reg <= '0;
            end
            else if (state_reg == sphc_pkg::ST_DIV && div_done && axis_reg != 2'd2)
            begin
                axis_reg <= axis_reg + 2'd1;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_slot_reg <= req.slot;
        end
        if (state_reg == sphc_pkg::ST_LOAD && !at_end)
        begin
            if (is_a)
            begin
                a_cell_reg <= head;
            end
            b_slot_reg <= sphc_pkg::SLOT_W'(k_reg);
            rel_x_reg  <= sphc_pkg::REL_W'(a_cell_reg.x) - sphc_pkg::REL_W'(head.x);
            rel_y_reg  <= sphc_pkg::REL_W'(a_cell_reg.y) - sphc_pkg::REL_W'(head.y);
            rel_z_reg  <= sphc_pkg::REL_W'(a_cell_reg.z) - sphc_pkg::REL_W'(head.z);
            tr_reg     <= sphc_pkg::DEPTH_W'(a_cell_reg.r) + sphc_pkg::DEPTH_W'(head.r);
        end
        if (state_reg == sphc_pkg::ST_SQ)
        begin
            sq_x_reg <= mag_x * mag_x;
            sq_y_reg <= mag_y * mag_y;
            sq_z_reg <= mag_z * mag_z;
            tr2_reg  <= tr_reg * tr_reg;
        end
        if (state_reg == sphc_pkg::ST_SQRT && sqrt_done)
        begin
            dist_reg <= sqrt_root;
        end
        if (state_reg == sphc_pkg::ST_NORM && dist_reg == '0)
        begin
            nx_reg <= '0;
            ny_reg <= '0;
            nz_reg <= '0;
        end
        if (state_reg == sphc_pkg::ST_DIV && div_done)
        begin
            case (axis_reg)
                2'd0:    nx_reg <= norm_val;
                2'd1:    ny_reg <= norm_val;
                default: nz_reg <= norm_val;
            endcase
        end
        if (state_reg == sphc_pkg::ST_EMIT)
        begin
            pend_reg <= new_rec;
        end
        if (emit)
        begin
            res_reg <= emit_rec;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

/* rtl/sphc_check.sv */
module sphc_check (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input sphc_pkg::sphc_req_t req,
    input logic                res_valid,
    input sphc_pkg::sphc_res_t res
);

    // A write beat finishes at once and never raises busy.
    a_write_quick: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && req.req_type == sphc_pkg::REQ_WRITE |=> !busy)
        else $error("write beat raised busy");

    // A scan beat holds busy until its records are out.
    a_scan_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && req.req_type == sphc_pkg::REQ_SCAN |=> busy)
        else $error("scan beat did not raise busy");

    // A no-hit record is always the only and final record of its scan.
    a_nohit_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.hit |-> res.last && res.depth == '0)
        else $error("no-hit record without last");

    // A hit names a higher partner and a nonzero depth.
    a_hit_pair: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.hit |-> res.slot_b > res.slot_a && res.depth != '0)
        else $error("bad hit pair or depth");

    // Nothing follows the final record directly.
    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.last |=> !res_valid)
        else $error("record right after last");

endmodule

bind sphere_pair_collision_scan_core sphc_check u_sphc_check (.*);

/* tb/tb_sphere_pair_collision_scan_core.sv */
`timescale 1ns / 100ps

module tb_sphere_pair_collision_scan_core;

    localparam int unsigned SLOTS       = 64;
    localparam int unsigned STALL_LIMIT = 40000;
    localparam int unsigned DRAIN_WAIT  = 200;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    sphc_pkg::sphc_req_t req;
    logic                res_valid;
    sphc_pkg::sphc_res_t res;

    // Shadow copy of the collider table, updated on every accepted write beat
    logic                              tbl_active [SLOTS];
    logic signed [sphc_pkg::POS_W-1:0] tbl_x      [SLOTS];
    logic signed [sphc_pkg::POS_W-1:0] tbl_y      [SLOTS];
    logic signed [sphc_pkg::POS_W-1:0] tbl_z      [SLOTS];
    logic [sphc_pkg::RAD_W-1:0]        tbl_r      [SLOTS];

    // Records the scanner owes us, oldest first
    sphc_pkg::sphc_res_t pending_records [$];
    int unsigned         mismatch_cnt = 0;
    int unsigned         quiet_cycles = 0;

    sphere_pair_collision_scan_core #(
        .NUM_SLOTS(SLOTS)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .req      (req),
        .res_valid(res_valid),
        .res      (res)
    );

    always #2 clk = ~clk;

    // Floor of the square root, bit by bit
    function automatic longint unsigned root_floor(input longint unsigned v);
        longint unsigned acc;
        longint unsigned probe;
        acc   = 0;
        probe = 64'h1 << 62;
        while (probe > v)
            probe >>= 2;
        while (probe != 0)
        begin
            if (v >= acc + probe)
            begin
                v   = v - (acc + probe);
                acc = (acc >> 1) + probe;
            end
            else
                acc >>= 1;
            probe >>= 2;
        end
        return acc;
    endfunction

    // One normal component in Q1.14, rounded half away from zero
    function automatic logic [sphc_pkg::NORM_W-1:0] unit_comp(
        input longint signed rel, input longint unsigned root_len);
        longint unsigned mag;
        longint unsigned q;
        if (root_len == 0)
            return '0;
        mag = (rel < 0) ? longint'(-rel) : longint'(rel);
        q   = (mag * 16384 + root_len / 2) / root_len;
        return (rel < 0) ? sphc_pkg::NORM_W'(-q) : sphc_pkg::NORM_W'(q);
    endfunction

    // Apply one accepted beat to the shadow table and queue what it causes
    task automatic predict_beat(input sphc_pkg::sphc_req_t r);
        int unsigned         a;
        int unsigned         hits;
        longint signed       rx;
        longint signed       ry;
        longint signed       rz;
        longint unsigned     d2;
        longint unsigned     tr;
        longint unsigned     root_len;
        sphc_pkg::sphc_res_t rec;
        a    = r.slot;
        hits = 0;
        if (r.req_type == sphc_pkg::REQ_WRITE)
        begin
            tbl_active[a] = r.active;
            if (r.active)
            begin
                tbl_x[a] = r.pos_x;
                tbl_y[a] = r.pos_y;
                tbl_z[a] = r.pos_z;
                tbl_r[a] = r.radius;
            end
            return;
        end
        if (tbl_active[a])
        begin
            for (int unsigned b = a + 1; b < SLOTS; b++)
            begin
                if (!tbl_active[b])
                    continue;
                rx = longint'(tbl_x[a]) - longint'(tbl_x[b]);
                ry = longint'(tbl_y[a]) - longint'(tbl_y[b]);
                rz = longint'(tbl_z[a]) - longint'(tbl_z[b]);
                d2 = rx * rx + ry * ry + rz * rz;
                tr = longint'(tbl_r[a]) + longint'(tbl_r[b]);
                if (d2 < tr * tr)
                begin
                    root_len     = root_floor(d2);
                    rec.hit      = 1'b1;
                    rec.slot_a   = sphc_pkg::SLOT_W'(a);
                    rec.slot_b   = sphc_pkg::SLOT_W'(b);
                    rec.normal_x = unit_comp(rx, root_len);
                    rec.normal_y = unit_comp(ry, root_len);
                    rec.normal_z = unit_comp(rz, root_len);
                    rec.depth    = sphc_pkg::DEPTH_W'(tr - root_len);
                    rec.last     = 1'b0;
                    pending_records = {pending_records, rec};
                    hits++;
                end
            end
        end
        if (hits == 0)
        begin
            rec        = '0;
            rec.slot_a = sphc_pkg::SLOT_W'(a);
            rec.last   = 1'b1;
            pending_records = {pending_records, rec};
        end
        else
            pending_records[pending_records.size() - 1].last = 1'b1;
    endtask

    // Mostly back to back, sometimes a short gap, rarely a long pause
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // Drive one beat, hold it until taken, then leave a random gap
    task automatic send_beat(input sphc_pkg::sphc_req_t r);
        int unsigned gap;
        @(negedge clk);
        start <= 1'b1;
        req   <= r;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        predict_beat(r);
        gap = pick_gap();
        if (gap != 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            req   <= sphc_pkg::sphc_req_t'({$urandom, $urandom, $urandom, $urandom});
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    function automatic sphc_pkg::sphc_req_t make_write(input int unsigned s,
                                                       input logic act,
                                                       input int px, input int py,
                                                       input int pz,
                                                       input int unsigned rad);
        sphc_pkg::sphc_req_t r;
        r.req_type = sphc_pkg::REQ_WRITE;
        r.slot     = sphc_pkg::SLOT_W'(s);
        r.active   = act;
        r.pos_x    = sphc_pkg::POS_W'(px);
        r.pos_y    = sphc_pkg::POS_W'(py);
        r.pos_z    = sphc_pkg::POS_W'(pz);
        r.radius   = sphc_pkg::RAD_W'(rad);
        return r;
    endfunction

    function automatic sphc_pkg::sphc_req_t make_scan(input int unsigned s);
        sphc_pkg::sphc_req_t r;
        r          = sphc_pkg::sphc_req_t'({$urandom, $urandom, $urandom, $urandom});
        r.req_type = sphc_pkg::REQ_SCAN;
        r.slot     = sphc_pkg::SLOT_W'(s);
        return r;
    endfunction

    task automatic check_field(input string name, input longint unsigned exp_v,
                               input longint unsigned act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            mismatch_cnt++;
        end
    endtask

    // Compare every record against the oldest one owed
    always @(posedge clk)
    begin
        sphc_pkg::sphc_res_t want;
        if (rst_n && res_valid)
        begin
            if (pending_records.size() == 0)
            begin
                $error("unexpected record: slot_a %0d slot_b %0d", res.slot_a, res.slot_b);
                mismatch_cnt++;
            end
            else
            begin
                want = pending_records.pop_front();
                check_field("hit", want.hit, res.hit);
                check_field("slot_a", want.slot_a, res.slot_a);
                check_field("slot_b", want.slot_b, res.slot_b);
                check_field("normal_x", want.normal_x, res.normal_x);
                check_field("normal_y", want.normal_y, res.normal_y);
                check_field("normal_z", want.normal_z, res.normal_z);
                check_field("depth", want.depth, res.depth);
                check_field("last", want.last, res.last);
            end
        end
    end

    // Watchdog: end the run if neither side moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || res_valid)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Extremes of every field: corner positions, widest radii, coinciding centers
    task automatic test_field_extremes();
        send_beat(make_scan(0));
        send_beat(make_write(0, 1'b1, 8388607, -8388608, 0, 8388607));
        send_beat(make_write(1, 1'b1, -8388608, 8388607, 8388607, 8388607));
        send_beat(make_write(63, 1'b1, 0, 0, -8388608, 0));
        send_beat(make_scan(0));
        send_beat(make_write(2, 1'b1, 8388607, -8388608, 0, 1));
        send_beat(make_write(3, 1'b1, 8388607, -8388608, 0, 0));
        send_beat(make_scan(0));
        send_beat(make_scan(2));
        send_beat(make_scan(63));
    endtask

    // No overlap, destroyed slots, inactive scanned slot, touching spheres
    task automatic test_special_cases();
        send_beat(make_write(10, 1'b1, 0, 0, 0, 4096));
        send_beat(make_write(11, 1'b1, 8192, 0, 0, 4096));
        send_beat(make_write(12, 1'b1, 8191, 0, 0, 4096));
        send_beat(make_write(13, 1'b1, -100, 300, -700, 2048));
        send_beat(make_scan(10));
        send_beat(make_write(12, 1'b0, 0, 0, 0, 0));
        send_beat(make_scan(10));
        send_beat(make_scan(12));
        send_beat(make_write(12, 1'b1, 1, 1, 1, 8));
        send_beat(make_scan(11));
        send_beat(make_scan(13));
        send_beat(make_scan(40));
    endtask

    // Well-formed traffic: clustered spheres so most scans find many overlaps
    task automatic test_random_cluster(input int unsigned beats);
        sphc_pkg::sphc_req_t r;
        for (int unsigned i = 0; i < beats; i++)
        begin
            if ($urandom_range(99) < 55)
            begin
                r = make_write($urandom_range(63), ($urandom_range(9) != 0),
                               $signed($urandom_range(32768)) - 16384,
                               $signed($urandom_range(32768)) - 16384,
                               $signed($urandom_range(32768)) - 16384,
                               $urandom_range(16384, 256));
                send_beat(r);
            end
            else
                send_beat(make_scan($urandom_range(63)));
        end
    endtask

    // Noise: every bit of every field random
    task automatic test_random_noise(input int unsigned beats);
        for (int unsigned i = 0; i < beats; i++)
            send_beat(sphc_pkg::sphc_req_t'({$urandom, $urandom, $urandom, $urandom}));
    endtask

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        start        = 1'b0;
        req          = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            tbl_active[i] = 1'b0;
            tbl_x[i]      = '0;
            tbl_y[i]      = '0;
            tbl_z[i]      = '0;
            tbl_r[i]      = '0;
        end
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_field_extremes();
        test_special_cases();
        test_random_cluster(100);
        test_random_noise(30);

        @(negedge clk);
        start <= 1'b0;
        // Drain: hold until every owed record is back, then let the pipe settle
        while (pending_records.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatch_cnt == 0 && pending_records.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
